// ===== hw/rtl/ssm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo sweep metronome package
// Register indexes, reset values and fixed widths shared by the metronome RTL.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TICK_W     = 16;
  localparam int ANGLE_W    = 8;
  localparam int TOL_W      = 7;
  localparam int PULSE_W    = 11;

  // Dividend width of the sweep progress division: ticks (16) times distance (8)
  localparam int DIV_W      = TICK_W + ANGLE_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_MID = 8'd90;
  localparam logic [TICK_W-1:0]  TICK_SAT  = 16'hFFFF;

  localparam logic [PULSE_W-1:0] PULSE_BASE = 11'd1000;
  // ceil(2^16 / 9): x / 9 == (x * RECIP9) >> 16 for x up to 9000
  localparam logic [12:0]        RECIP9     = 13'd7282;

  localparam logic [TICK_W-1:0] BEAT_RST     = 16'd1500;
  localparam logic [TICK_W-1:0] BEEP_RST     = 16'd100;
  localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd200;
  localparam logic [TICK_W-1:0] SETTLE_RST   = 16'd100;
  localparam logic [TOL_W-1:0]  TOL_RST      = 7'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAT_MS     = 3'd0,
    CFG_BEEP_MS     = 3'd1,
    CFG_PRESS_GAP   = 3'd2,
    CFG_SETTLE_MS   = 3'd3,
    CFG_NEAR_TOL    = 3'd4
  } cfg_idx_t;

  // Distance in degrees from the midpoint
  function automatic logic [ANGLE_W-1:0] dist90(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] d;
    if (a >= ANGLE_MID) d = a - ANGLE_MID;
    else                d = ANGLE_MID - a;
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/servo_sweep_metronome_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A tick that does not move the servo goes straight to the output load; a sweeping tick
// passes through the multiply, 24 divider steps, the angle update and the output load.
// Only one tick is handled at a time: no new tick is taken until the last result is loaded.
// The output register frees the input side as soon as a result is loaded.
// Reset (rst, synchronous): stopped, angle 0, no beep, registers at their defaults.
// ----------------------------------------------------------------------------
// Servo sweep metronome
// Per millisecond tick: debounced start/stop button, alternating servo sweeps
// with settles, midpoint beep, and servo pulse width output.
// ----------------------------------------------------------------------------
module servo_sweep_metronome_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [ssm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssm_pkg::CFG_DATA_W-1:0] cfg_data,
  // tick input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           button_level,
  // result output
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ssm_pkg::PULSE_W-1:0]         pulse_us,
  output logic [ssm_pkg::ANGLE_W-1:0]         angle_deg,
  output logic                                beep_on,
  output logic                                running
);
  import ssm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [TICK_W-1:0] beat_ms, beep_ms, press_gap, settle_ms;
  logic [TOL_W-1:0]  near_tolerance;

  // metronome state
  logic               run_flag, phase, beat_index, beep_flag, button_prev;
  logic [ANGLE_W-1:0] angle, sweep_origin, prev_angle;
  logic [TICK_W-1:0]  phase_ticks, beep_left, since_press;

  // sweep progress divider
  logic [DIV_W-1:0]     div_num;
  logic [TICK_W-1:0]    div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic accept;
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Tick control: phase ends, settle count and button handling
  logic               t_run, t_phase, t_bi, t_beep, t_bprev, t_sweep;
  logic               in_settle, do_read, press;
  logic [ANGLE_W-1:0] t_angle, t_start, t_prev;
  logic [TICK_W-1:0]  t_ticks, t_left, t_since;

  always_comb begin
    t_since   = since_press;
    t_run     = run_flag;
    t_phase   = phase;
    t_bi      = beat_index;
    t_angle   = angle;
    t_start   = sweep_origin;
    t_prev    = prev_angle;
    t_ticks   = phase_ticks;
    t_beep    = beep_flag;
    t_left    = beep_left;
    t_bprev   = button_prev;
    in_settle = 1'b0;
    if (since_press != TICK_SAT) t_since = since_press + 16'd1;
    if (run_flag) begin
      // finish a sweep: jump to target, turn round, settle
      if (phase && (phase_ticks >= beat_ms)) begin
        t_angle = beat_index ? '0 : ANGLE_MAX;
        t_bi    = ~beat_index;
        t_phase = 1'b0;
        t_ticks = '0;
      end
      if (!t_phase) begin
        if (t_ticks >= settle_ms) begin
          t_beep  = 1'b0;
          t_left  = '0;
          t_phase = 1'b1;
          t_ticks = '0;
          t_start = t_angle;
          t_prev  = t_angle;
        end else begin
          t_ticks   = t_ticks + 16'd1;
          in_settle = 1'b1;
        end
      end
    end
    do_read = !in_settle;
    press   = do_read && !button_level && button_prev && (t_since > press_gap);
    if (do_read) t_bprev = button_level;
    if (press) begin
      t_since = '0;
      t_angle = '0;
      t_beep  = 1'b0;
      t_left  = '0;
      t_run   = ~run_flag;
      if (!run_flag) begin
        t_phase = 1'b0;
        t_ticks = '0;
        t_bi    = 1'b0;
      end
    end
    t_sweep = run_flag && do_read && !press;
  end

  // Sweep geometry from the registered start angle
  logic               sw_up;
  logic [ANGLE_W-1:0] sw_dist;
  always_comb begin
    if (!beat_index) begin
      sw_up   = (sweep_origin < ANGLE_MAX);
      sw_dist = sw_up ? ANGLE_MAX - sweep_origin : sweep_origin - ANGLE_MAX;
    end else begin
      sw_up   = 1'b0;
      sw_dist = sweep_origin;
    end
  end

  // One restoring divider step
  logic [TICK_W:0]   rem_sh, trial;
  logic              q_bit;
  logic [TICK_W-1:0] rem_next;
  always_comb begin
    rem_sh   = {div_rem, div_num[DIV_W-1]};
    trial    = rem_sh - {1'b0, beat_ms};
    q_bit    = !trial[TICK_W];
    rem_next = q_bit ? trial[TICK_W-1:0] : rem_sh[TICK_W-1:0];
  end

  // Sweep update: angle from quotient, beep on approach to the midpoint
  logic [ANGLE_W-1:0] sw_done, sw_angle, pd, cd;
  logic [ANGLE_W:0]   sw_sum;
  logic               sw_beep, sw_fresh;
  logic [TICK_W-1:0]  sw_left;
  always_comb begin
    if (beat_ms == '0)                          sw_done = sw_dist;
    else if (div_num > DIV_W'(sw_dist))         sw_done = sw_dist;
    else                                        sw_done = div_num[ANGLE_W-1:0];
    sw_sum = {1'b0, sweep_origin} + {1'b0, sw_done};
    if (sw_up)                        sw_angle = sw_sum[ANGLE_W-1:0];
    else if (sw_done > sweep_origin)  sw_angle = '0;
    else                              sw_angle = sweep_origin - sw_done;
    if (sw_up && (sw_sum > {1'b0, ANGLE_MAX})) sw_angle = ANGLE_MAX;
    pd       = dist90(prev_angle);
    cd       = dist90(sw_angle);
    sw_beep  = beep_flag;
    sw_left  = beep_left;
    sw_fresh = 1'b0;
    if (!beep_flag && (pd > cd) && (cd <= {1'b0, near_tolerance})) begin
      sw_beep  = 1'b1;
      sw_left  = beep_ms;
      sw_fresh = 1'b1;
    end
    if (sw_beep) begin
      if (!sw_fresh && (sw_left != '0)) sw_left = sw_left - 16'd1;
      if (sw_left == '0) sw_beep = 1'b0;
    end
  end

  // Pulse width: 1000 + angle * 50 / 9
  logic [13:0] ang50;
  logic [26:0] pulse_prod;
  logic [PULSE_W-1:0] pulse_calc;
  always_comb begin
    ang50      = {1'b0, angle, 5'b0} + {2'b0, angle, 4'b0} + {5'b0, angle, 1'b0};
    pulse_prod = 27'(ang50) * 27'(RECIP9);
    pulse_calc = PULSE_BASE + pulse_prod[26:16];
  end

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      beat_ms        <= BEAT_RST;
      beep_ms        <= BEEP_RST;
      press_gap      <= DEBOUNCE_RST;
      settle_ms      <= SETTLE_RST;
      near_tolerance <= TOL_RST;
      run_flag       <= 1'b0;
      phase          <= 1'b0;
      beat_index     <= 1'b0;
      angle          <= '0;
      sweep_origin   <= '0;
      prev_angle     <= '0;
      phase_ticks    <= '0;
      beep_flag      <= 1'b0;
      beep_left      <= '0;
      button_prev    <= 1'b1;
      since_press    <= TICK_SAT;
      div_cnt        <= '0;
      out_valid      <= 1'b0;
    end else begin
      // write configuration
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BEAT_MS:     beat_ms        <= cfg_data;
          CFG_BEEP_MS:     beep_ms        <= cfg_data;
          CFG_PRESS_GAP:   press_gap      <= cfg_data;
          CFG_SETTLE_MS:   settle_ms      <= cfg_data;
          CFG_NEAR_TOL:    near_tolerance <= cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end
      // drop the result once transferred, unless a new one is loaded below
      if (out_ready && (state != ST_EMIT)) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            run_flag     <= t_run;
            phase        <= t_phase;
            beat_index   <= t_bi;
            angle        <= t_angle;
            sweep_origin <= t_start;
            prev_angle   <= t_prev;
            phase_ticks  <= t_ticks;
            beep_flag    <= t_beep;
            beep_left    <= t_left;
            button_prev  <= t_bprev;
            since_press  <= t_since;
            state        <= t_sweep ? ST_MUL : ST_EMIT;
          end
        end
        ST_MUL: begin
          div_num <= DIV_W'(phase_ticks) * DIV_W'(sw_dist);
          div_rem <= '0;
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_num <= {div_num[DIV_W-2:0], q_bit};
          div_rem <= rem_next;
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(DIV_W - 1)) state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          angle      <= sw_angle;
          prev_angle <= sw_angle;
          beep_flag  <= sw_beep;
          beep_left  <= sw_left;
          if (phase_ticks != TICK_SAT) phase_ticks <= phase_ticks + 16'd1;
          state      <= ST_EMIT;
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            pulse_us    <= pulse_calc;
            angle_deg   <= angle;
            beep_on     <= beep_flag;
            running     <= run_flag;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_deg <= ANGLE_MAX))
    else $error("servo angle beyond full travel");

  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pulse_us >= PULSE_BASE) && (pulse_us <= 11'd2000))
    else $error("pulse width out of range");

  a_stop_quiet: assert property (@(posedge clk) disable iff (rst)
    !run_flag |-> !beep_flag && (angle == '0))
    else $error("beep or angle left over while stopped");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_cnt <= DIV_CNT_W'(DIV_W - 1)))
    else $error("divider step count overran");

  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("new tick taken before the last one finished");

endmodule
`default_nettype wire
